/* rtl/core/fgc_pkg.sv */
// ----------------------------------------------------------------------------
// fgc_pkg: shared definitions for the fade gain curve block
// Fixed-point formats, register codes and the constant tables. The tables
// are computed at elaboration with exact integer arithmetic.
// ----------------------------------------------------------------------------
package fgc_pkg;

  // Position and gain formats. One is unity gain.
  localparam int FracBits = 16;
  localparam int PosW     = FracBits + 2;
  localparam int GainW    = FracBits + 1;
  localparam logic [GainW-1:0] One = GainW'(1) << FracBits;

  // Stream and configuration port widths.
  localparam int PosTdataW  = ((PosW + 7) / 8) * 8;
  localparam int GainTdataW = ((GainW + 7) / 8) * 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  // Power curve exponent, unsigned Q4.12.
  localparam int ExpW     = 16;
  localparam int ExpFrac  = 12;
  localparam logic [ExpW-1:0] ExpReset = ExpW'(8192);

  // log2 / exp2 internal formats.
  localparam int LgFrac   = 24;
  localparam int MantFrac = 30;
  localparam int MantW    = MantFrac + 1;
  localparam int EW       = $clog2(FracBits + 1);

  // Cycles from the register that drives the power unit input to its result register.
  localparam int PowLatency = 2 * LgFrac + 4;

  // Logarithmic curve table.
  localparam int LogTableDepth = 256;
  localparam int LogIdxW       = $clog2(LogTableDepth);

  typedef enum logic [1:0] {
    CurveLinear,
    CurvePower,
    CurveSmooth,
    CurveLog
  } curve_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegCurveType,
    RegExponent,
    RegFadeIn
  } cfg_reg_t;

  typedef logic [LgFrac:1][MantW-1:0] root_tab_t;
  typedef logic [LogTableDepth-1:0][GainW-1:0] log_tab_t;

  // Floor square root, one result bit per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // log2 of a positive integer with LgFrac fraction bits, by repeated squaring
  // of the normalized mantissa.
  function automatic logic [31:0] log2_int(input logic [63:0] x);
    logic [63:0] m;
    logic [LgFrac-1:0] fr;
    int e;
    e = 0;
    for (int j = 0; j < 64; j++) if (x[j]) e = j;
    if (e > MantFrac) m = x >> (e - MantFrac);
    else m = x << (MantFrac - e);
    fr = '0;
    for (int i = 1; i <= LgFrac; i++) begin
      m = (m * m) >> MantFrac;
      if (m >= (64'd2 << MantFrac)) begin
        m = m >> 1;
        fr[LgFrac-i] = 1'b1;
      end
    end
    return (32'(e) << LgFrac) | 32'(fr);
  endfunction

  localparam logic [31:0] LogBase = log2_int(64'(LogTableDepth));
  localparam logic [31:0] LogSpan = log2_int(64'(LogTableDepth) * 64'd10) - LogBase;

  // Entry i is log10(1 + 9 i / depth) in gain format, rounded to nearest.
  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    logic [63:0] d;
    logic [63:0] v;
    for (int i = 0; i < LogTableDepth; i++) begin
      d = 64'(log2_int(64'(LogTableDepth) + 64'd9 * 64'(i)) - LogBase);
      v = (d * 64'(One) + 64'(LogSpan / 2)) / LogSpan;
      if (v > 64'(One)) v = 64'(One);
      t[i] = v[GainW-1:0];
    end
    return t;
  endfunction

  // Entry i is 2^(2^-i) with MantFrac fraction bits, floor square roots.
  function automatic root_tab_t build_root_tab();
    root_tab_t t;
    logic [63:0] r;
    r = 64'd2 << MantFrac;
    for (int i = 1; i <= LgFrac; i++) begin
      r = isqrt64(r << MantFrac);
      t[i] = r[MantW-1:0];
    end
    return t;
  endfunction

  localparam log_tab_t  LogTab  = build_log_tab();
  localparam root_tab_t RootTab = build_root_tab();

endpackage

/* rtl/core/fgc_power.sv */
// ----------------------------------------------------------------------------
// fgc_power: pipelined power curve, pos ^ exponent
// log2 by one mantissa squaring per stage, a scaling multiply, then 2^-y by
// one conditional root-table product per stage and a rounding shift.
// ----------------------------------------------------------------------------
module fgc_power
  import fgc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [GainW-1:0] pos,
  input  logic [ExpW-1:0]  exponent,
  output logic [GainW-1:0] gain
);

  localparam int MagW  = EW + LgFrac;
  localparam int ProdW = MagW + ExpW;
  localparam int TW    = ProdW - ExpFrac;
  localparam int KW    = TW - LgFrac;
  localparam int ShW   = $clog2(FracBits + 2);

  // log2 stages; entry 0 is the normalized input.
  logic [MantW-1:0]    lg_m  [LgFrac+1];
  logic [LgFrac-1:0]   lg_fr [LgFrac+1];
  logic [EW-1:0]       lg_e  [LgFrac+1];
  logic [MantW-1:0]    lg_m_next  [1:LgFrac];
  logic [LgFrac-1:0]   lg_fr_next [1:LgFrac];
  logic [2*MantW-1:0]  sq     [1:LgFrac];
  logic [MantW:0]      sq_top [1:LgFrac];

  logic [EW-1:0]    norm_e;
  logic [MantW-1:0] norm_m;

  logic [MagW-1:0]  mag;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] prod_rnd;
  logic [TW-1:0]    tval;
  logic [LgFrac-1:0] tfrac;
  logic [KW:0]      keff;

  // exp2 stages; entry 0 holds the split of the scaled logarithm.
  logic [MantW-1:0]   ex_acc  [LgFrac+1];
  logic [LgFrac-1:0]  ex_g    [LgFrac+1];
  logic [ShW-1:0]     ex_sh   [LgFrac+1];
  logic               ex_zero [LgFrac+1];
  logic [MantW-1:0]   ex_acc_next [1:LgFrac];
  logic [2*MantW-1:0] mul [1:LgFrac];

  logic [MantW:0]   fin_rnd;
  logic [MantW:0]   fin_res;
  logic [GainW-1:0] gain_next;

  always_comb begin
    norm_e = '0;
    for (int j = 0; j < GainW; j++) if (pos[j]) norm_e = EW'(j);
    norm_m = MantW'(pos) << (MantFrac - int'(norm_e));
  end

  always_comb begin
    for (int i = 1; i <= LgFrac; i++) begin
      sq[i]         = lg_m[i-1] * lg_m[i-1];
      sq_top[i]     = sq[i][MantFrac +: MantW+1];
      lg_fr_next[i] = lg_fr[i-1];
      lg_fr_next[i][LgFrac-i] = sq_top[i][MantW];
      lg_m_next[i]  = sq_top[i][MantW] ? sq_top[i][MantW:1] : sq_top[i][MantW-1:0];
    end
  end

  // |log2(pos)| = (FracBits - e) - fraction, then scaled by the exponent.
  always_comb begin
    mag      = {EW'(FracBits) - lg_e[LgFrac], LgFrac'(0)} - MagW'(lg_fr[LgFrac]);
    prod_rnd = prod + (ProdW'(1) << (ExpFrac - 1));
    tval     = prod_rnd[ProdW-1:ExpFrac];
    tfrac    = tval[LgFrac-1:0];
    keff     = {1'b0, tval[TW-1:LgFrac]} + (KW+1)'(tfrac != '0);
  end

  always_comb begin
    for (int i = 1; i <= LgFrac; i++) begin
      mul[i]         = ex_acc[i-1] * RootTab[i];
      ex_acc_next[i] = ex_g[i-1][LgFrac-i] ? mul[i][MantFrac +: MantW] : ex_acc[i-1];
    end
  end

  always_comb begin
    fin_rnd = (MantW+1)'(ex_acc[LgFrac])
            + ((MantW+1)'(1) << (MantFrac - FracBits - 1 + int'(ex_sh[LgFrac])));
    fin_res = fin_rnd >> (MantFrac - FracBits + int'(ex_sh[LgFrac]));
    gain_next = ex_zero[LgFrac] ? '0 : fin_res[GainW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m[0]  <= norm_m;
      lg_e[0]  <= norm_e;
      lg_fr[0] <= '0;
      for (int i = 1; i <= LgFrac; i++) begin
        lg_m[i]  <= lg_m_next[i];
        lg_fr[i] <= lg_fr_next[i];
        lg_e[i]  <= lg_e[i-1];
      end

      prod <= ProdW'(mag) * ProdW'(exponent);

      // A nonzero fraction f becomes 2^(1 - f) with one more shift place.
      ex_acc[0]  <= MantW'(1) << MantFrac;
      ex_g[0]    <= LgFrac'(0) - tfrac;
      ex_sh[0]   <= keff[ShW-1:0];
      ex_zero[0] <= keff > (KW+1)'(FracBits + 1);
      for (int i = 1; i <= LgFrac; i++) begin
        ex_acc[i]  <= ex_acc_next[i];
        ex_g[i]    <= ex_g[i-1];
        ex_sh[i]   <= ex_sh[i-1];
        ex_zero[i] <= ex_zero[i-1];
      end

      gain <= gain_next;
    end
  end

endmodule

/* rtl/core/fade_gain_curve.sv */
// ----------------------------------------------------------------------------
// fade_gain_curve: fade position to gain mapping
// Clamps a Q1.16 position to [0, 1] and applies a linear, power, smoothstep
// or logarithmic curve, optionally mirrored for a fade-out.
// ----------------------------------------------------------------------------
// The block takes one position per clock while s_axis_tready is high and
// returns one gain per position, in order. The pipeline depth is set by the
// power curve, whose log2 takes one mantissa squaring per stage (24 stages)
// and whose 2^x takes one root-table product per stage (24 stages), each
// stage holding a single multiplier. The other curves finish in three stages
// and are carried alongside so all results leave in order. An output
// register backed by a one-entry skid buffer decouples the two sides:
// s_axis_tready is registered and drops only once both hold a result that
// the sink has not taken. Configuration writes are accepted in every cycle
// and should only be issued while no position is in flight.
module fade_gain_curve
  import fgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,

  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PosTdataW-1:0]  s_axis_tdata,   // [17:0] position (signed Q1.16)

  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [GainTdataW-1:0] m_axis_tdata,   // [16:0] gain (unsigned Q1.16)

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CfgIdxW-1:0]    cfg_index,
  input  logic [CfgDataW-1:0]   cfg_data
);

  localparam int MulW = 2 * GainW + 1;
  localparam logic [GainW:0] ThreeOne = {One, 1'b0} + {1'b0, One};

  // Result of the short curves, or a marker that the power unit supplies it.
  typedef struct packed {
    logic             use_pow;
    logic [GainW-1:0] gain;
  } side_t;

  // Configuration registers.
  curve_t          curve_type;
  logic [ExpW-1:0] exponent;
  logic            fade_in;

  // Pipeline control: one valid bit per stage, stage 0 is the entry register.
  logic                  adv;
  logic [PowLatency:0]   valid_pipe;

  // Stage 0: clamped position.
  logic [PosW-1:0]  pos_in;
  logic [GainW-1:0] pos_clamped;
  logic [GainW-1:0] p0;

  // Stage 1: square for smoothstep, table pair for the logarithmic curve.
  logic [LogIdxW-1:0]    log_idx;
  logic [GainW-1:0]      log_a;
  logic [GainW-1:0]      log_b;
  logic [GainW-1:0]      p1;
  logic [2*GainW-1:0]    sqp1;
  logic [GainW-1:0]      a1;
  logic [GainW-1:0]      b1;
  logic [FracBits-1:0]   fr1;

  // Stage 2: the shared second multiply.
  logic [2*GainW-1:0] sq_sum;
  logic [GainW-1:0]   sq2;
  logic [GainW:0]     w2;
  logic               up_next;
  logic [GainW-1:0]   diff2;
  logic [GainW-1:0]   mul_a;
  logic [GainW:0]     mul_b;
  logic [GainW-1:0]   p2;
  logic [GainW-1:0]   a2;
  logic               up2;
  logic [MulW-1:0]    prod2;

  // Stage 3 and the delay line that matches the power unit.
  logic [MulW-1:0]          rnd3;
  logic [MulW-FracBits-1:0] r3;
  side_t                    side3_next;
  side_t                    side_pipe [3:PowLatency];

  // Final selection and output buffering.
  logic [GainW-1:0] pow_gain;
  logic [GainW-1:0] g_sel;
  logic [GainW-1:0] g_clip;
  logic [GainW-1:0] fin_gain;
  logic             out_valid;
  logic [GainW-1:0] out_gain;
  logic             skid_valid;
  logic [GainW-1:0] skid_gain;
  logic             out_free;
  logic             last_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_type <= CurveLinear;
      exponent   <= ExpReset;
      fade_in    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegCurveType: curve_type <= curve_t'(cfg_data[1:0]);
        RegExponent:  exponent   <= cfg_data[ExpW-1:0];
        RegFadeIn:    fade_in    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only while the skid buffer
  // is occupied, so ready comes straight from a register.
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;
  assign last_valid    = valid_pipe[PowLatency];

  // Negative positions give zero, positions above unity give unity.
  always_comb begin
    pos_in = s_axis_tdata[PosW-1:0];
    if (pos_in[PosW-1]) begin
      pos_clamped = '0;
    end else if (pos_in[PosW-2:0] > One) begin
      pos_clamped = One;
    end else begin
      pos_clamped = pos_in[GainW-1:0];
    end
  end

  // Table lookup: index is the top bits of pos * depth, the rest is the
  // interpolation weight. The entry past the end is unity.
  always_comb begin
    log_idx = p0[FracBits-1 -: LogIdxW];
    log_a   = LogTab[log_idx];
    log_b   = (log_idx == '1) ? One : LogTab[LogIdxW'(log_idx + 1'b1)];
  end

  // Smoothstep squares and weights by (3 - 2t); the logarithmic curve scales
  // the table step by the weight. Only one of them is in use at a time, so
  // they share a multiplier.
  always_comb begin
    sq_sum  = sqp1 + (2*GainW)'(One >> 1);
    sq2     = sq_sum[FracBits +: GainW];
    w2      = ThreeOne - {p1, 1'b0};
    up_next = b1 >= a1;
    diff2   = up_next ? (b1 - a1) : (a1 - b1);
    if (curve_type == CurveSmooth) begin
      mul_a = sq2;
      mul_b = w2;
    end else begin
      mul_a = diff2;
      mul_b = (GainW+1)'(fr1);
    end
  end

  always_comb begin
    rnd3       = prod2 + MulW'(One >> 1);
    r3         = rnd3[MulW-1:FracBits];
    side3_next = '0;
    unique case (curve_type)
      CurveLinear: begin
        side3_next.gain = p2;
      end
      CurvePower: begin
        // Zero exponent is unity everywhere; zero position is silence.
        side3_next.use_pow = (exponent != '0) && (p2 != '0);
        side3_next.gain    = (exponent == '0) ? One : '0;
      end
      CurveSmooth: begin
        side3_next.gain = (r3 > (MulW-FracBits)'(One)) ? One : r3[GainW-1:0];
      end
      CurveLog: begin
        if (p2[FracBits]) begin
          side3_next.gain = One;
        end else if (up2) begin
          side3_next.gain = a2 + r3[GainW-1:0];
        end else begin
          side3_next.gain = a2 - r3[GainW-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (adv) begin
      valid_pipe <= {valid_pipe[PowLatency-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0   <= pos_clamped;

      p1   <= p0;
      sqp1 <= (2*GainW)'(p0) * (2*GainW)'(p0);
      a1   <= log_a;
      b1   <= log_b;
      fr1  <= {p0[FracBits-LogIdxW-1:0], LogIdxW'(0)};

      p2    <= p1;
      a2    <= a1;
      up2   <= up_next;
      prod2 <= MulW'(mul_a) * MulW'(mul_b);

      side_pipe[3] <= side3_next;
      for (int i = 4; i <= PowLatency; i++) side_pipe[i] <= side_pipe[i-1];
    end
  end

  fgc_power u_power (
    .clk      (clk),
    .en       (adv),
    .pos      (p0),
    .exponent (exponent),
    .gain     (pow_gain)
  );

  // Pick the curve result, limit it to unity and mirror it for a fade-out.
  always_comb begin
    g_sel    = side_pipe[PowLatency].use_pow ? pow_gain : side_pipe[PowLatency].gain;
    g_clip   = (g_sel > One) ? One : g_sel;
    fin_gain = fade_in ? g_clip : (One - g_clip);
  end

  // The output register is free when empty or being taken. A result that
  // leaves the pipeline while the output is held goes to the skid buffer,
  // which then drains first.
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= adv && last_valid;
      end
    end else if (adv && last_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_gain <= skid_gain;
      end else begin
        out_gain <= fin_gain;
      end
    end else if (adv && last_valid) begin
      skid_gain <= fin_gain;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = GainTdataW'(out_gain);

`ifndef ASSERT_OFF
  // The skid buffer only fills behind a held output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid buffer occupied while output register is empty");

  // A result leaving the pipeline always lands in the output or skid buffer.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (adv && last_valid) |=> (out_valid || skid_valid))
    else $error("pipeline result dropped at the output buffer");

  // Every delivered gain lies within [0, unity].
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_gain <= One))
    else $error("gain above unity");
`endif

endmodule
